>>> hdl/cbpmn_pkg.sv
// package for the complex base point minimum norm unit
// holds the microcode format, sequencer codes, program rom and radix tables
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cbpmn_pkg;

  localparam int PcW = 4;

  // datapath operations
  localparam logic [3:0] OpLoad = 4'd0;
  localparam logic [3:0] OpNop  = 4'd1;
  localparam logic [3:0] OpMulQ = 4'd2;
  localparam logic [3:0] OpMulR = 4'd3;
  localparam logic [3:0] OpCorr = 4'd4;
  localparam logic [3:0] OpAcc  = 4'd5;
  localparam logic [3:0] OpAbs  = 4'd6;
  localparam logic [3:0] OpSq   = 4'd7;
  localparam logic [3:0] OpSum  = 4'd8;
  localparam logic [3:0] OpFin  = 4'd9;

  // branch conditions
  localparam logic [1:0] CndNext     = 2'd0;
  localparam logic [1:0] CndRestZero = 2'd1;
  localparam logic [1:0] CndRestNz   = 2'd2;
  localparam logic [1:0] CndWait     = 2'd3;

  // register map
  localparam logic [2:0] AddrRealPart = 3'd0;

  localparam logic [63:0] CoordLimit = 64'd2147483647;
  localparam logic [63:0] NoneYet    = '1;

  typedef struct packed {
    logic [3:0]     op;
    logic [1:0]     cond;
    logic [PcW-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic go;
    logic rest_zero;
  } seq_stat_t;

  // program: one control word per step
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    unique case (pc)
      4'd0:    w = '{op: OpLoad, cond: CndWait,     target: 4'd1};
      4'd1:    w = '{op: OpNop,  cond: CndRestZero, target: 4'd6};
      4'd2:    w = '{op: OpMulQ, cond: CndNext,     target: 4'd0};
      4'd3:    w = '{op: OpMulR, cond: CndNext,     target: 4'd0};
      4'd4:    w = '{op: OpCorr, cond: CndNext,     target: 4'd0};
      4'd5:    w = '{op: OpAcc,  cond: CndRestNz,   target: 4'd2};
      4'd6:    w = '{op: OpAbs,  cond: CndNext,     target: 4'd0};
      4'd7:    w = '{op: OpSq,   cond: CndNext,     target: 4'd0};
      4'd8:    w = '{op: OpSum,  cond: CndNext,     target: 4'd0};
      4'd9:    w = '{op: OpFin,  cond: CndWait,     target: 4'd0};
      default: w = '{op: OpNop,  cond: CndWait,     target: 4'd0};
    endcase
    return w;
  endfunction

  // digit radix r*r+1, real part zero reads as one
  function automatic logic [7:0] radix_of(input logic [3:0] r);
    logic [7:0] d;
    unique case (r)
      4'd0, 4'd1: d = 8'd2;
      4'd2:  d = 8'd5;
      4'd3:  d = 8'd10;
      4'd4:  d = 8'd17;
      4'd5:  d = 8'd26;
      4'd6:  d = 8'd37;
      4'd7:  d = 8'd50;
      4'd8:  d = 8'd65;
      4'd9:  d = 8'd82;
      4'd10: d = 8'd101;
      4'd11: d = 8'd122;
      4'd12: d = 8'd145;
      4'd13: d = 8'd170;
      4'd14: d = 8'd197;
      default: d = 8'd226;
    endcase
    return d;
  endfunction

  // floor(2^32 / radix), quotient estimate is short by at most one
  function automatic logic [31:0] recip_of(input logic [3:0] r);
    logic [31:0] m;
    unique case (r)
      4'd0, 4'd1: m = 32'd2147483648;
      4'd2:  m = 32'd858993459;
      4'd3:  m = 32'd429496729;
      4'd4:  m = 32'd252645135;
      4'd5:  m = 32'd165191049;
      4'd6:  m = 32'd116080197;
      4'd7:  m = 32'd85899345;
      4'd8:  m = 32'd66076419;
      4'd9:  m = 32'd52377649;
      4'd10: m = 32'd42524428;
      4'd11: m = 32'd35204649;
      4'd12: m = 32'd29620464;
      4'd13: m = 32'd25264513;
      4'd14: m = 32'd21801864;
      default: m = 32'd19004280;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> hdl/complex_base_point_min_norm_unit.sv
// top level of the complex base point minimum norm unit
// depends on cbpmn_pkg and cbpmn_seq
`timescale 1ns / 1ps
`default_nettype none

// Reads each index word as digits in radix r*r+1 (r from the real_part register,
// zero read as one), sums digit times (r+i)^k into a point and reports the point,
// its squared distance and the running minimum since the last restart. One item is
// worked at a time by a microcoded sequencer over a shared datapath: a new index is
// taken only after the last one has passed its final step, and every digit of an
// index passes the four-step divide, correct and accumulate loop. A finished word
// waits in the output register while the next index runs; the unit only holds in
// its last step if that register is still full and not being read.
module complex_base_point_min_norm_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        index,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] point_x,
  output logic signed [47:0] point_y,
  output logic [62:0]        dist_sq,
  output logic               skipped,
  output logic [63:0]        best_dist_sq,
  output logic [31:0]        best_index,
  output logic [30:0]        best_abs_x,
  output logic [30:0]        best_abs_y
);
  import cbpmn_pkg::*;

  ucode_t     uword;
  seq_stat_t  stat;

  logic [3:0]  real_part;
  logic [3:0]  r_eff;
  logic [7:0]  radix;
  logic [31:0] recip;

  logic [31:0] rest;
  logic [31:0] qest;
  logic [8:0]  rem;
  logic [7:0]  digit;
  logic [31:0] idx;
  logic [63:0] x;
  logic [63:0] y;
  logic [63:0] px;
  logic [63:0] py;
  logic [30:0] ax;
  logic [30:0] ay;
  logic        skip;
  logic [61:0] sqx;
  logic [61:0] sqy;
  logic [62:0] h;

  logic [63:0] min_dist;
  logic [31:0] min_index;
  logic [30:0] min_ax;
  logic [30:0] min_ay;

  logic [63:0] qfull;
  logic [39:0] qd;
  logic [31:0] diff;
  logic [63:0] dpx;
  logic [63:0] dpy;
  logic [63:0] pxr;
  logic [63:0] pyr;
  logic [63:0] ax_full;
  logic [63:0] ay_full;
  logic        better;
  logic        out_free;

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    prdata = (paddr == AddrRealPart) ? {28'd0, real_part} : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      real_part <= 4'd3;
    end else if (psel && penable && pwrite && paddr == AddrRealPart) begin
      real_part <= pwdata[3:0];
    end
  end

  assign r_eff = (real_part == 4'd0) ? 4'd1 : real_part;
  assign radix = radix_of(real_part);
  assign recip = recip_of(real_part);

  cbpmn_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .stat  (stat),
    .uword (uword)
  );

  assign out_free = !out_valid || out_ready;
  assign in_ready = (uword.op == OpLoad);
  assign stat     = '{go:        ((uword.op == OpLoad) ? in_valid : out_free),
                      rest_zero: (rest == 32'd0)};

  // datapath arithmetic
  assign qfull   = {32'd0, rest} * {32'd0, recip};
  assign qd      = {8'd0, qest} * {32'd0, radix};
  assign diff    = rest - qd[31:0];
  assign dpx     = px * {56'd0, digit};
  assign dpy     = py * {56'd0, digit};
  assign pxr     = px * {60'd0, r_eff};
  assign pyr     = py * {60'd0, r_eff};
  assign ax_full = x[63] ? (~x + 64'd1) : x;
  assign ay_full = y[63] ? (~y + 64'd1) : y;
  assign better  = !skip && ({1'b0, h} < min_dist);

  always_ff @(posedge clk) begin
    unique case (uword.op)
      OpLoad: begin
        rest <= index;
        idx  <= index;
        x    <= '0;
        y    <= '0;
        px   <= 64'd1;
        py   <= '0;
      end
      OpMulQ: qest <= qfull[63:32];
      OpMulR: rem  <= diff[8:0];
      OpCorr: begin
        // estimate may be one short
        if (rem >= {1'b0, radix}) begin
          digit <= 8'(rem - {1'b0, radix});
          rest  <= qest + 32'd1;
        end else begin
          digit <= rem[7:0];
          rest  <= qest;
        end
      end
      OpAcc: begin
        x  <= x + dpx;
        y  <= y + dpy;
        px <= pxr - py;
        py <= px + pyr;
      end
      OpAbs: begin
        skip <= (ax_full > CoordLimit) || (ay_full > CoordLimit);
        ax   <= ax_full[30:0];
        ay   <= ay_full[30:0];
      end
      OpSq: begin
        sqx <= ax * ax;
        sqy <= ay * ay;
      end
      OpSum:   h <= skip ? 63'd0 : {1'b0, sqx} + {1'b0, sqy};
      default: ;
    endcase
  end

  // running minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist  <= NoneYet;
      min_index <= '0;
      min_ax    <= '0;
      min_ay    <= '0;
    end else if (uword.op == OpLoad && in_valid && restart) begin
      min_dist  <= NoneYet;
      min_index <= '0;
      min_ax    <= '0;
      min_ay    <= '0;
    end else if (uword.op == OpFin && out_free && better) begin
      min_dist  <= {1'b0, h};
      min_index <= idx;
      min_ax    <= ax;
      min_ay    <= ay;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uword.op == OpFin && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uword.op == OpFin && out_free) begin
      point_x      <= x[47:0];
      point_y      <= y[47:0];
      dist_sq      <= h;
      skipped      <= skip;
      best_dist_sq <= better ? {1'b0, h} : min_dist;
      best_index   <= better ? idx : min_index;
      best_abs_x   <= better ? ax : min_ax;
      best_abs_y   <= better ? ay : min_ay;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cbpmn_seq.sv
// microcode sequencer: step counter, program rom and branch logic
// depends on cbpmn_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbpmn_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  cbpmn_pkg::seq_stat_t  stat,
  output cbpmn_pkg::ucode_t     uword
);
  import cbpmn_pkg::*;

  logic [PcW-1:0] pc;
  logic [PcW-1:0] pc_next;

  assign uword = ucode_rom(pc);

  always_comb begin
    unique case (uword.cond)
      CndNext:     pc_next = pc + 1'b1;
      CndRestZero: pc_next = stat.rest_zero ? uword.target : pc + 1'b1;
      CndRestNz:   pc_next = stat.rest_zero ? pc + 1'b1 : uword.target;
      CndWait:     pc_next = stat.go ? uword.target : pc;
      default:     pc_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cbpmn_chk.sv
// port level checks for the complex base point minimum norm unit
// depends on complex_base_point_min_norm_unit, attached by the bind below
`timescale 1ns / 1ps
`default_nettype none

module cbpmn_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] point_x,
  input logic [62:0] dist_sq,
  input logic        skipped,
  input logic [63:0] best_dist_sq,
  input logic [31:0] best_index,
  input logic [30:0] best_abs_x
);

  // a word that waits keeps its point
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_x))
    else $error("output word changed while stalled");

  // only one index in flight
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("index taken while another is in flight");

  a_skip: assert property (@(posedge clk) disable iff (rst)
    out_valid && skipped |-> dist_sq == 63'd0)
    else $error("skipped point with nonzero distance");

  a_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && !skipped |-> best_dist_sq <= {1'b0, dist_sq})
    else $error("running minimum above current distance");

  a_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && best_dist_sq == '1 |-> best_index == 32'd0 && best_abs_x == 31'd0)
    else $error("empty minimum with stale index");

endmodule

bind complex_base_point_min_norm_unit cbpmn_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .point_x      (point_x),
  .dist_sq      (dist_sq),
  .skipped      (skipped),
  .best_dist_sq (best_dist_sq),
  .best_index   (best_index),
  .best_abs_x   (best_abs_x)
);

`default_nettype wire
